// ===== hdl/prod_pkg.sv =====
// Shared constants, types and the sequencer state enum for the power rise onset detector.
// No dependencies; used by every file under hdl.
package prod_pkg;

   localparam int MAX_LOOKAHEAD = 64;
   localparam int WIN_DEPTH     = MAX_LOOKAHEAD + 1;
   localparam int ADDR_W        = $clog2(WIN_DEPTH);
   localparam int LK_W          = $clog2(MAX_LOOKAHEAD + 1);
   localparam int FILL_W        = $clog2(WIN_DEPTH + 1);

   localparam int PWR_W   = 16;
   localparam int SLOPE_W = PWR_W + 1;
   localparam int STEP_W  = 24;
   localparam int THR_W   = 15;
   localparam int LKCFG_W = 7;
   localparam int CSR_W   = 15;
   localparam int CSRA_W  = 1;

   localparam logic [CSRA_W-1:0] CSR_RISE_THRESHOLD = 1'b0;
   localparam logic [CSRA_W-1:0] CSR_LOOKAHEAD      = 1'b1;

   localparam logic [THR_W-1:0]   RISE_THRESHOLD_RST = 15'd1536;
   localparam logic [LKCFG_W-1:0] LOOKAHEAD_RST      = 7'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLAN,
      ST_J_ADDR,
      ST_J_CUR,
      ST_J_NXT,
      ST_J_SLOPE,
      ST_SCAN,
      ST_NEXT,
      ST_FINISH,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic                    en;
      logic [ADDR_W-1:0]       addr;
      logic signed [PWR_W-1:0] data;
   } win_wr_type;

   function automatic logic [LK_W-1:0] eff_lookahead(input logic [LKCFG_W-1:0] cfg);
      logic [LK_W-1:0] l;
      if (cfg == '0) begin
         l = LK_W'(1);
      end else if (32'(cfg) > MAX_LOOKAHEAD) begin
         l = LK_W'(MAX_LOOKAHEAD);
      end else begin
         l = LK_W'(cfg);
      end
      return l;
   endfunction

endpackage

// ===== hdl/prod_window_ram.sv =====
// Circular window of recent power values: one write port, one registered read port.
// Depends on prod_pkg.
module prod_window_ram (
   input  logic                                clock,
   input  prod_pkg::win_wr_type                wr,
   input  logic [prod_pkg::ADDR_W-1:0]         rd_addr,
   output logic signed [prod_pkg::PWR_W-1:0]   rd_data
);

   logic signed [prod_pkg::PWR_W-1:0] mem [prod_pkg::WIN_DEPTH];
   logic signed [prod_pkg::PWR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/power_rise_onset_detector_top.sv =====
// Top level of the power rise onset detector: sequencer, compare datapath, result buffer.
// Depends on prod_pkg and prod_window_ram.
//
//  port group | dir | tdata bits (low first)     | tuser / tlast
//  req_       | in  | power_db [15:0] signed     | tlast = final_step
//  rsp_       | out | onset_step [23:0]          | tlast = run_end
//  csr_       | in  | write data [14:0]          | addr 0 rise_threshold, 1 lookahead_steps
//
// Request time is set by the walk over the window RAM's single read port, one value per
// cycle, up to the effective lookahead L; a request with no judged step skips the walk,
// and a final request also walks each flushed step. Each response passes through the
// output register.
// Reset is synchronous; req_tready stays low in reset, while a request is being worked on and
// while buffered responses wait for the output register.
module power_rise_onset_detector_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic signed [prod_pkg::PWR_W-1:0]   req_tdata,   // power_db
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [prod_pkg::STEP_W-1:0]         rsp_tdata,   // onset_step
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [prod_pkg::CSRA_W-1:0]         csr_addr,
   input  logic [prod_pkg::CSR_W-1:0]          csr_wdata
);

   prod_pkg::state_type state_ff, state_in;

   logic [prod_pkg::THR_W-1:0]          thr_ff;
   logic [prod_pkg::LKCFG_W-1:0]        lkcfg_ff;
   logic [prod_pkg::ADDR_W-1:0]         wpos_ff, wpos_in;
   logic [prod_pkg::FILL_W-1:0]         fill_ff;
   logic [prod_pkg::STEP_W-1:0]         step_ff;
   logic                                pending_ff;
   logic signed [prod_pkg::SLOPE_W-1:0] prev_slope_ff;
   logic                                last_ff;
   logic [prod_pkg::LK_W-1:0]           lk_ff;
   logic [prod_pkg::LK_W-1:0]           d_ff;
   logic [prod_pkg::LK_W-1:0]           j_ff;
   logic                                scan_ff;
   logic [prod_pkg::ADDR_W-1:0]         addr_ff;
   logic signed [prod_pkg::PWR_W-1:0]   cur_ff;
   logic signed [prod_pkg::SLOPE_W-1:0] limit_ff;
   logic [prod_pkg::STEP_W-1:0]         res_ff [2];
   logic [1:0]                          n_ff;
   logic                                o_ff;
   logic                                rsp_valid_ff;
   logic [prod_pkg::STEP_W-1:0]         rsp_data_ff;
   logic                                rsp_last_ff;

   prod_pkg::win_wr_type                win_wr;
   logic signed [prod_pkg::PWR_W-1:0]   rd_data;

   logic                                accept;
   logic                                judge_done;
   logic                                rec_onset;
   logic                                set_pending;
   logic                                rsp_load;
   logic                                full_judge;
   logic                                flush_go;

   logic [prod_pkg::FILL_W-1:0]         fill_m1, lk_m1, dmax_w;
   logic [prod_pkg::LK_W-1:0]           dmax;
   logic [prod_pkg::ADDR_W:0]           addr_sum;
   logic [prod_pkg::ADDR_W-1:0]         addr_start;
   logic [prod_pkg::ADDR_W-1:0]         addr_inc;
   logic signed [prod_pkg::SLOPE_W-1:0] slope;
   logic                                slope_lt;
   logic                                v_lt_cur;
   logic                                v_gt_lim;
   logic                                scan_end;

   prod_window_ram u_ram (
      .clock   (clock),
      .wr      (win_wr),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // datapath
   always_comb begin
      wpos_in  = (32'(wpos_ff) == prod_pkg::WIN_DEPTH - 1) ? '0 : wpos_ff + 1'b1;
      addr_inc = (32'(addr_ff) == prod_pkg::WIN_DEPTH - 1) ? '0 : addr_ff + 1'b1;
      addr_sum = {1'b0, wpos_ff} + (prod_pkg::ADDR_W + 1)'(prod_pkg::WIN_DEPTH)
                 - (prod_pkg::ADDR_W + 1)'(d_ff);
      addr_start = (32'(addr_sum) >= prod_pkg::WIN_DEPTH)
                   ? prod_pkg::ADDR_W'(32'(addr_sum) - prod_pkg::WIN_DEPTH)
                   : addr_sum[prod_pkg::ADDR_W-1:0];
      fill_m1  = fill_ff - 1'b1;
      lk_m1    = prod_pkg::FILL_W'(lk_ff) - 1'b1;
      dmax_w   = (lk_m1 < fill_m1) ? lk_m1 : fill_m1;
      dmax     = dmax_w[prod_pkg::LK_W-1:0];
      full_judge = fill_ff >= prod_pkg::FILL_W'(lk_ff) + 1'b1;
      flush_go = last_ff && (dmax != '0);
      slope    = {rd_data[prod_pkg::PWR_W-1], rd_data} - {cur_ff[prod_pkg::PWR_W-1], cur_ff};
      slope_lt = slope < prev_slope_ff;
      v_lt_cur = rd_data < cur_ff;
      v_gt_lim = $signed({rd_data[prod_pkg::PWR_W-1], rd_data}) > limit_ff;
      scan_end = j_ff == lk_ff;
   end

   // sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      judge_done  = 1'b0;
      rec_onset   = 1'b0;
      set_pending = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         prod_pkg::ST_IDLE: begin
            req_tready = !reset;
         end
         prod_pkg::ST_J_SLOPE: begin
            if (pending_ff) begin
               rec_onset  = slope_lt;
               judge_done = 1'b1;
            end else if (scan_ff) begin
               set_pending = !v_lt_cur && v_gt_lim;
               judge_done  = v_lt_cur || v_gt_lim || (lk_ff == prod_pkg::LK_W'(1));
            end else begin
               judge_done = 1'b1;
            end
         end
         prod_pkg::ST_SCAN: begin
            set_pending = !v_lt_cur && v_gt_lim;
            judge_done  = v_lt_cur || v_gt_lim || scan_end;
         end
         prod_pkg::ST_DRAIN: begin
            rsp_load = (n_ff != '0) && (!rsp_valid_ff || rsp_tready);
         end
         default: begin
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_comb begin
      win_wr.en   = accept;
      win_wr.addr = wpos_in;
      win_wr.data = req_tdata;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prod_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = prod_pkg::ST_PLAN;
            end
         end
         prod_pkg::ST_PLAN: begin
            state_in = (full_judge || flush_go) ? prod_pkg::ST_J_ADDR : prod_pkg::ST_FINISH;
         end
         prod_pkg::ST_J_ADDR:  state_in = prod_pkg::ST_J_CUR;
         prod_pkg::ST_J_CUR:   state_in = prod_pkg::ST_J_NXT;
         prod_pkg::ST_J_NXT:   state_in = prod_pkg::ST_J_SLOPE;
         prod_pkg::ST_J_SLOPE: begin
            state_in = judge_done ? prod_pkg::ST_NEXT : prod_pkg::ST_SCAN;
         end
         prod_pkg::ST_SCAN: begin
            if (judge_done) begin
               state_in = prod_pkg::ST_NEXT;
            end
         end
         prod_pkg::ST_NEXT: begin
            if (scan_ff) begin
               state_in = flush_go ? prod_pkg::ST_J_ADDR : prod_pkg::ST_FINISH;
            end else begin
               state_in = (d_ff <= prod_pkg::LK_W'(1)) ? prod_pkg::ST_FINISH
                                                        : prod_pkg::ST_J_ADDR;
            end
         end
         prod_pkg::ST_FINISH: state_in = prod_pkg::ST_DRAIN;
         prod_pkg::ST_DRAIN: begin
            if (n_ff == '0 || (rsp_load && (2'(o_ff) + 2'd1 == n_ff))) begin
               state_in = prod_pkg::ST_IDLE;
            end
         end
         default: state_in = prod_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= prod_pkg::ST_IDLE;
         thr_ff        <= prod_pkg::RISE_THRESHOLD_RST;
         lkcfg_ff      <= prod_pkg::LOOKAHEAD_RST;
         wpos_ff       <= '0;
         fill_ff       <= '0;
         step_ff       <= '0;
         pending_ff    <= 1'b0;
         prev_slope_ff <= '0;
         last_ff       <= 1'b0;
         n_ff          <= '0;
         o_ff          <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_addr)
               prod_pkg::CSR_RISE_THRESHOLD: thr_ff <= csr_wdata[prod_pkg::THR_W-1:0];
               prod_pkg::CSR_LOOKAHEAD: lkcfg_ff <= csr_wdata[prod_pkg::LKCFG_W-1:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            wpos_ff <= wpos_in;
            if (32'(fill_ff) < prod_pkg::WIN_DEPTH) begin
               fill_ff <= fill_ff + 1'b1;
            end
            last_ff <= req_tlast;
            n_ff    <= '0;
            o_ff    <= 1'b0;
         end
         if (state_ff == prod_pkg::ST_J_SLOPE) begin
            prev_slope_ff <= slope;
            if (rec_onset) begin
               pending_ff <= 1'b0;
            end
         end
         if (set_pending) begin
            pending_ff <= 1'b1;
         end
         if (rec_onset && n_ff != 2'd2) begin
            n_ff <= n_ff + 1'b1;
         end
         if (state_ff == prod_pkg::ST_FINISH) begin
            if (last_ff) begin
               pending_ff    <= 1'b0;
               prev_slope_ff <= '0;
               step_ff       <= '0;
               fill_ff       <= '0;
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            o_ff         <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         lk_ff <= prod_pkg::eff_lookahead(lkcfg_ff);
      end
      case (state_ff)
         prod_pkg::ST_PLAN: begin
            scan_ff <= full_judge;
            d_ff    <= full_judge ? lk_ff : dmax;
         end
         prod_pkg::ST_NEXT: begin
            scan_ff <= 1'b0;
            d_ff    <= scan_ff ? dmax : d_ff - 1'b1;
         end
         prod_pkg::ST_J_ADDR: begin
            addr_ff <= addr_start;
         end
         prod_pkg::ST_J_CUR: begin
            addr_ff <= addr_inc;
         end
         prod_pkg::ST_J_NXT: begin
            addr_ff  <= addr_inc;
            cur_ff   <= rd_data;
            limit_ff <= {rd_data[prod_pkg::PWR_W-1], rd_data}
                        + $signed({2'b00, thr_ff});
         end
         prod_pkg::ST_J_SLOPE: begin
            addr_ff <= addr_inc;
            j_ff    <= prod_pkg::LK_W'(2);
         end
         prod_pkg::ST_SCAN: begin
            addr_ff <= addr_inc;
            j_ff    <= j_ff + 1'b1;
         end
         default: begin
         end
      endcase
      if (rec_onset && n_ff != 2'd2) begin
         res_ff[n_ff[0]] <= step_ff - prod_pkg::STEP_W'(d_ff);
      end
      if (rsp_load) begin
         rsp_data_ff <= res_ff[o_ff];
         rsp_last_ff <= 2'(o_ff) + 2'd1 == n_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/prod_checker.sv =====
// Port-level checks for the power rise onset detector, bound to the top level.
// Depends on prod_pkg and power_rise_onset_detector_top.
module prod_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [prod_pkg::STEP_W-1:0]         rsp_tdata,
   input logic                                rsp_tlast
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_rst_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a response needs the judge walk first
   a_rsp_late: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid) ##1 !$rose(rsp_tvalid))
      else $error("response too soon after request");

endmodule

bind power_rise_onset_detector_top prod_checker u_prod_checker (.*);

// ===== test/power_rise_onset_detector_top_tb.sv =====
// Self-checking bench for power_rise_onset_detector_top: streams power contours with bursty
// requests and a stalling receiver, and checks each onset against an in-bench predictor.
// Depends on prod_pkg and the RTL under hdl.
module power_rise_onset_detector_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN       = prod_pkg::WIN_DEPTH;
   localparam int SETTLE    = 600;
   localparam int CYCLE_CAP = 3_000_000;

   typedef struct {
      logic signed [prod_pkg::PWR_W-1:0] power;
      logic                              seq_end;
      bit                                drain_first;
   } req_item_type;

   typedef struct {
      logic [prod_pkg::STEP_W-1:0] step;
      logic                        run_end;
   } onset_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic signed [prod_pkg::PWR_W-1:0]   req_tdata = '0;
   logic                                req_tlast = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [prod_pkg::STEP_W-1:0]         rsp_tdata;
   logic                                rsp_tlast;
   logic                                csr_we = 1'b0;
   logic [prod_pkg::CSRA_W-1:0]         csr_addr = '0;
   logic [prod_pkg::CSR_W-1:0]          csr_wdata = '0;

   // predictor state
   logic signed [prod_pkg::PWR_W-1:0] pwr_hist [WIN];
   int                                hist_pos = 0;
   int                                hist_fill = 0;
   int                                last_slope = 0;
   bit                                rise_armed = 1'b0;
   logic [prod_pkg::STEP_W-1:0]       step_idx = '0;
   logic [prod_pkg::THR_W-1:0]        thr_reg = prod_pkg::RISE_THRESHOLD_RST;
   logic [prod_pkg::LKCFG_W-1:0]      lk_reg = prod_pkg::LOOKAHEAD_RST;

   req_item_type req_q[$];
   onset_type    onset_q[$];
   req_item_type cur_req;
   int           queued_cnt = 0;
   int           accepted_cnt = 0;
   int           err_cnt = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   int           rx_mode = 0;
   longint       rx_tick = 0;
   longint       cyc_cnt = 0;

   power_rise_onset_detector_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic int window_span();
      if (lk_reg == '0) return 1;
      if (int'(lk_reg) > prod_pkg::MAX_LOOKAHEAD) return prod_pkg::MAX_LOOKAHEAD;
      return int'(lk_reg);
   endfunction

   function automatic int hist_at(int back);
      return int'(pwr_hist[(hist_pos + WIN - back) % WIN]);
   endfunction

   function automatic bit judge_step(int back, bit scan, int lk);
      int cur, slope, lim, v;
      bit hit;
      cur = hist_at(back);
      slope = hist_at(back - 1) - cur;
      hit = 1'b0;
      if (rise_armed) begin
         if (slope < last_slope) begin
            hit = 1'b1;
            rise_armed = 1'b0;
         end
      end else if (scan) begin
         lim = cur + int'(thr_reg);
         for (int j = 0; j <= lk; j++) begin
            v = hist_at(back - j);
            if (v < cur) break;
            if (v > lim) begin
               rise_armed = 1'b1;
               break;
            end
         end
      end
      last_slope = slope;
      return hit;
   endfunction

   function automatic void predict_onsets(logic signed [prod_pkg::PWR_W-1:0] power,
                                          logic seq_end);
      int                          lk, top;
      bit                          hit;
      logic [prod_pkg::STEP_W-1:0] k;
      onset_type                   found[$];
      onset_type                   o;
      lk = window_span();
      k = step_idx;
      hist_pos = (hist_pos + 1) % WIN;
      pwr_hist[hist_pos] = power;
      if (hist_fill < WIN) hist_fill++;
      if (hist_fill >= lk + 1) begin
         hit = judge_step(lk, 1'b1, lk);
         if (hit) begin
            o.step = k - prod_pkg::STEP_W'(lk);
            o.run_end = 1'b0;
            found = {found, o};
         end
      end
      if (seq_end) begin
         // flush: steps without full lookahead, slopes only
         top = lk - 1;
         if (top > hist_fill - 1) top = hist_fill - 1;
         for (int d = top; d >= 1; d--) begin
            hit = judge_step(d, 1'b0, lk);
            if (hit && found.size() < 2) begin
               o.step = k - prod_pkg::STEP_W'(d);
               o.run_end = 1'b0;
               found = {found, o};
            end
         end
         rise_armed = 1'b0;
         last_slope = 0;
         step_idx = '0;
         hist_fill = 0;
      end else begin
         step_idx = step_idx + 1'b1;
      end
      if (found.size() > 0) found[found.size() - 1].run_end = 1'b1;
      foreach (found[i]) onset_q = {onset_q, found[i]};
   endfunction

   function automatic void push_req(int power, bit seq_end, bit drain_first);
      req_item_type it;
      it.power = prod_pkg::PWR_W'(power);
      it.seq_end = seq_end;
      it.drain_first = drain_first;
      req_q = {req_q, it};
      queued_cnt++;
   endfunction

   // segments of flat, rising, falling, jumping and noisy power
   function automatic void queue_contour(int len, bit close);
      int lvl, seg_left, mode, delta, v;
      lvl = int'($urandom_range(0, 12000)) - 8000;
      seg_left = 0;
      mode = 0;
      delta = 0;
      for (int i = 0; i < len; i++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(1, 8);
            mode = $urandom_range(0, 9);
            case (mode)
               0, 1, 2: delta = int'($urandom_range(0, 80)) - 40;
               3, 4, 5: delta = int'($urandom_range(40, 1400));
               6, 7:    delta = -int'($urandom_range(20, 900));
               default: delta = 0;
            endcase
         end
         seg_left--;
         if (mode == 8) lvl = int'($urandom_range(0, 65535)) - 32768;
         else lvl += delta;
         if (lvl > 32767) lvl = 32767;
         if (lvl < -32768) lvl = -32768;
         v = (mode == 9) ? int'($urandom_range(0, 65535)) - 32768 : lvl;
         push_req(v, close && (i == len - 1), $urandom_range(0, 99) == 0);
      end
   endfunction

   task automatic report_mismatch(string what, longint want, longint got);
      $display("ERROR @%0t %s: expected %0d, got %0d", $time, what, want, got);
      err_cnt++;
   endtask

   task automatic write_csr(input logic [prod_pkg::CSRA_W-1:0] idx, input int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= prod_pkg::CSR_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == prod_pkg::CSR_RISE_THRESHOLD) thr_reg = prod_pkg::THR_W'(value);
      else lk_reg = prod_pkg::LKCFG_W'(value);
   endtask

   task automatic wait_idle();
      while (accepted_cnt != queued_cnt || onset_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   always @(posedge clock) begin : drive_req
      bit fire, show;
      fire = req_tvalid && req_tready;
      show = req_tvalid && !req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
      end else begin
         if (fire) begin
            predict_onsets(cur_req.power, cur_req.seq_end);
            accepted_cnt++;
         end
         if (!show) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (req_q.size() != 0 &&
                         !(req_q[0].drain_first && onset_q.size() != 0)) begin
               cur_req = req_q.pop_front();
               show = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         req_tvalid <= show;
         if (show) begin
            req_tdata <= cur_req.power;
            req_tlast <= cur_req.seq_end;
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      onset_type want;
      logic      rdy;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (onset_q.size() == 0) begin
               report_mismatch("response with none pending", -1, rsp_tdata);
            end else begin
               want = onset_q.pop_front();
               if (rsp_tdata !== want.step) report_mismatch("onset_step", want.step, rsp_tdata);
               if (rsp_tlast !== want.run_end)
                  report_mismatch("run_end", want.run_end, rsp_tlast);
            end
         end
         rx_tick++;
         if (rx_tick % 200 == 0) rx_mode = $urandom_range(0, 3);
         case (rx_mode)
            0:       rdy = 1'b1;
            1:       rdy = $urandom_range(0, 1);
            2:       rdy = (rx_tick % 5) == 0;
            default: rdy = (rx_tick % 16) >= 12;
         endcase
         rsp_tready <= rdy;
      end
   end

   always @(posedge clock) begin : watchdog
      cyc_cnt++;
      if (cyc_cnt > CYCLE_CAP) begin
         $display("power_rise_onset_detector_top: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      int thr, lk, target, count, len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: lone final request, short run, then a clear rise
      push_req(32767, 1'b1, 1'b0);
      push_req(-32768, 1'b0, 1'b0);
      push_req(32767, 1'b1, 1'b0);
      for (int i = 0; i < 6; i++) push_req(0, 1'b0, 1'b0);
      push_req(100, 1'b0, 1'b0);
      push_req(300, 1'b0, 1'b0);
      push_req(2500, 1'b0, 1'b0);
      push_req(4000, 1'b0, 1'b0);
      push_req(4500, 1'b0, 1'b0);
      push_req(4600, 1'b0, 1'b0);
      push_req(4600, 1'b0, 1'b0);
      push_req(4600, 1'b0, 1'b0);
      push_req(-32768, 1'b0, 1'b0);
      push_req(32767, 1'b0, 1'b1);
      push_req(-32768, 1'b1, 1'b0);
      wait_idle();

      for (int ph = 0; ph < 14; ph++) begin
         case (ph)
            0: begin thr = 0;     lk = 1;   end
            1: begin thr = 32767; lk = 0;   end
            2: begin thr = 25600; lk = 64;  end
            3: begin thr = 300;   lk = 127; end
            4: begin thr = 1536;  lk = 65;  end
            default: begin
               thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                 : $urandom_range(0, 3000);
               lk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
            end
         endcase
         write_csr(prod_pkg::CSR_RISE_THRESHOLD, thr);
         write_csr(prod_pkg::CSR_LOOKAHEAD, lk);
         target = (window_span() > 16) ? 60 : 95;
         count = 0;
         // some runs stay open so a new lookahead lands mid-sequence
         while (count < target) begin
            len = $urandom_range(1, 2 * window_span() + 10);
            queue_contour(len, $urandom_range(0, 5) != 0);
            count += len;
         end
         wait_idle();
      end

      if (err_cnt == 0) begin
         $display("power_rise_onset_detector_top: match");
      end else begin
         $display("power_rise_onset_detector_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/prod_pkg.sv
hdl/prod_window_ram.sv
hdl/power_rise_onset_detector_top.sv
hdl/prod_checker.sv
test/power_rise_onset_detector_top_tb.sv
